// ===== rtl/fpsqrt_pkg.sv =====
package fpsqrt_pkg;

    localparam int SCALE_SHIFT = 32;
    localparam int OPND_W     = 64;
    localparam int ROOT_W     = 48;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int NUM_CELLS  = ROOT_W;

    localparam logic [ROOT_W-1:0] ROOT_MAX = 48'd199032864766430;

    typedef struct packed {
        logic              valid;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } t_cell;

endpackage

// ===== rtl/fixed_point_square_root_top.sv =====
// Each accepted input beat passes through the cell row to its result beat, one cell per root bit.
// Throughput: one beat per cycle; the 48-cell row moves as a whole and freezes
// when the final cell holds a result that the output side stalls.
// Reset: synchronous, active low; it clears the valid bit of every cell.
// Payload registers are not reset.
module fixed_point_square_root_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [fpsqrt_pkg::OPND_W-1:0] i_operand,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic        [fpsqrt_pkg::ROOT_W-1:0] o_root
);
    import fpsqrt_pkg::*;

    t_cell              w_link [NUM_CELLS+1];
    logic               w_adv;
    logic               w_pos;
    logic [RAD_W-1:0]   w_rad;

    assign w_adv   = !(w_link[NUM_CELLS].valid && i_stall);
    assign o_stall = !w_adv;

    assign w_pos = !i_operand[OPND_W-1] && (i_operand != '0);
    assign w_rad = RAD_W'(unsigned'(i_operand)) << SCALE_SHIFT;

    always_comb begin
        w_link[0].valid = i_valid;
        w_link[0].rem   = '0;
        w_link[0].root  = '0;
        w_link[0].rad   = w_pos ? w_rad : '0;
    end

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        fpsqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_cell  (w_link[g]),
            .o_cell  (w_link[g+1])
        );
    end

    assign o_valid = w_link[NUM_CELLS].valid;
    assign o_root  = w_link[NUM_CELLS].root;

`ifndef SYNTHESIS
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_root <= ROOT_MAX))
        else $error("root beyond the largest possible value");
`endif

endmodule

// ===== rtl/fpsqrt_cell.sv =====
module fpsqrt_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_adv,
    input  fpsqrt_pkg::t_cell   i_cell,
    output fpsqrt_pkg::t_cell   o_cell
);
    import fpsqrt_pkg::*;

    t_cell              r_cell;
    t_cell              n_cell;
    logic [REM_W+1:0]   w_rem_sh;
    logic [REM_W+1:0]   w_trial;
    logic [REM_W+1:0]   w_diff;
    logic               w_ge;

    always_comb begin
        w_rem_sh = {i_cell.rem, i_cell.rad[RAD_W-1 -: 2]};
        w_trial  = {2'b00, i_cell.root, 2'b01};
        w_diff   = w_rem_sh - w_trial;
        w_ge     = (w_rem_sh >= w_trial);

        n_cell.valid = i_cell.valid;
        n_cell.rem   = w_ge ? w_diff[REM_W-1:0] : w_rem_sh[REM_W-1:0];
        n_cell.root  = {i_cell.root[ROOT_W-2:0], w_ge};
        n_cell.rad   = {i_cell.rad[RAD_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell.valid <= 1'b0;
        end else if (i_adv) begin
            r_cell.valid <= n_cell.valid;
        end
        if (i_adv) begin
            r_cell.rem  <= n_cell.rem;
            r_cell.root <= n_cell.root;
            r_cell.rad  <= n_cell.rad;
        end
    end

    assign o_cell = r_cell;

`ifndef SYNTHESIS
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cell.valid |-> ({1'b0, r_cell.rem} <= {2'b00, r_cell.root, 1'b0}))
        else $error("remainder exceeds twice the partial root");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_cell))
        else $error("cell changed while the row was frozen");

    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv |=> (r_cell.valid == $past(i_cell.valid)))
        else $error("valid bit did not move with the row");
`endif

endmodule
